[sv/ac_ir_frame_pulse_encoder_top_macros.svh]
// Assertion macros for the encoder's checker file.
// No dependencies; include with the bare file name.
`ifndef AC_IR_FRAME_PULSE_ENCODER_TOP_MACROS_SVH
`define AC_IR_FRAME_PULSE_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ACIR_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ACIR_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/acirfpe_pkg.sv]
// Types, constants and frame-timing functions for the IR frame encoder.
// No dependencies; imported by the top level.
package acirfpe_pkg;

	localparam int DURATION_BITS = 16;
	typedef logic [DURATION_BITS-1:0] dur_t;
	typedef logic [7:0] pair_t;
	typedef logic [7:0] cmd_byte_t;

	// Frame layout
	localparam pair_t LAST_PAIR = 8'd135;
	localparam pair_t GAP_PAIR = 8'd67;
	localparam pair_t BLK0_START = 8'd1;
	localparam pair_t BLK1_START = 8'd34;
	localparam pair_t BLK2_START = 8'd69;
	localparam pair_t BLK3_START = 8'd102;
	localparam pair_t BLK0_END = 8'd32;
	localparam pair_t BLK1_END = 8'd65;
	localparam pair_t BLK2_END = 8'd100;

	// Command codes
	localparam cmd_byte_t FAN_HIGH = 8'h60;
	localparam cmd_byte_t FAN_MED = 8'h40;
	localparam cmd_byte_t FAN_LOW = 8'h20;
	localparam cmd_byte_t FAN_AUTO = 8'hF0;
	localparam cmd_byte_t MCODE_OFF = 8'h06;
	localparam cmd_byte_t MCODE_HEAT = 8'h0C;
	localparam cmd_byte_t MCODE_COOL = 8'h0A;
	localparam cmd_byte_t MCODE_DRY = 8'h0B;
	localparam cmd_byte_t MCODE_AUTO = 8'h0E;
	localparam cmd_byte_t SAME_MODE_FLAG = 8'h10;
	localparam cmd_byte_t FIXED_BYTE_C = 8'hF4;
	localparam cmd_byte_t FIXED_BYTE_D = 8'h36;

	typedef enum logic [1:0] {
		FAN_SEL_AUTO = 2'd0,
		FAN_SEL_LOW  = 2'd1,
		FAN_SEL_MED  = 2'd2,
		FAN_SEL_HIGH = 2'd3
	} fan_sel_t;

	typedef enum logic [2:0] {
		MODE_OFF  = 3'd0,
		MODE_HEAT = 3'd1,
		MODE_COOL = 3'd2,
		MODE_DRY  = 3'd3,
		MODE_AUTO = 3'd4
	} op_mode_t;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_TICK = 1'b1
	} action_t;

	// Register map (word index)
	typedef enum logic [2:0] {
		REG_LEAD  = 3'd0,
		REG_MARK  = 3'd1,
		REG_ONE   = 3'd2,
		REG_ZERO  = 3'd3,
		REG_GAP   = 3'd4,
		REG_TRAIL = 3'd5,
		REG_OFFS  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		dur_t lead;
		dur_t mark;
		dur_t one_sp;
		dur_t zero_sp;
		dur_t gap;
		dur_t trail;
		logic [5:0] temp_bias;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		lead: dur_t'(3500),
		mark: dur_t'(850),
		one_sp: dur_t'(2600),
		zero_sp: dur_t'(870),
		gap: dur_t'(14025),
		trail: dur_t'(50000),
		temp_bias: 6'd15
	};

	// A zero duration lasts one tick
	function automatic dur_t dur_or_one(input dur_t v);
		return (v == '0) ? dur_t'(1) : v;
	endfunction

	function automatic cmd_byte_t fan_code(input logic [1:0] fan);
		cmd_byte_t c;
		case (fan)
			FAN_SEL_HIGH: c = FAN_HIGH;
			FAN_SEL_MED:  c = FAN_MED;
			FAN_SEL_LOW:  c = FAN_LOW;
			default:      c = FAN_AUTO;
		endcase
		return c;
	endfunction

	// Mode is already clamped to auto for codes above auto
	function automatic cmd_byte_t mode_code(input logic [2:0] mode);
		cmd_byte_t c;
		case (mode)
			MODE_OFF:  c = MCODE_OFF;
			MODE_HEAT: c = MCODE_HEAT;
			MODE_COOL: c = MCODE_COOL;
			MODE_DRY:  c = MCODE_DRY;
			default:   c = MCODE_AUTO;
		endcase
		return c;
	endfunction

	function automatic logic is_lead_pair(input pair_t idx);
		return (idx == 8'd0) || (idx == 8'd33) || (idx == 8'd66) || (idx == 8'd68) ||
			(idx == 8'd101) || (idx == 8'd134);
	endfunction

	// Space of a data bit: 32 pairs per block, byte b0 twice then b1 twice, LSB first
	function automatic dur_t data_space(input pair_t idx, input pair_t start,
		input cmd_byte_t b0, input cmd_byte_t b1, input cfg_t cfg);
		pair_t k;
		cmd_byte_t byte_sel;
		k = idx - start;
		byte_sel = k[4] ? b1 : b0;
		return byte_sel[k[2:0]] ? dur_or_one(cfg.one_sp) : dur_or_one(cfg.zero_sp);
	endfunction

	// Duration of one half (mark or space) of a pair
	function automatic dur_t half_duration(input pair_t idx, input logic space,
		input cfg_t cfg, input cmd_byte_t tbyte, input cmd_byte_t mbyte);
		dur_t d;
		if (is_lead_pair(idx)) begin
			d = dur_or_one(cfg.lead);
		end else if (!space) begin
			d = dur_or_one(cfg.mark);
		end else if (idx == GAP_PAIR) begin
			d = dur_or_one(cfg.gap);
		end else if (idx >= LAST_PAIR) begin
			d = dur_or_one(cfg.trail);
		end else if (idx <= BLK1_END) begin
			d = data_space(idx, (idx <= BLK0_END) ? BLK0_START : BLK1_START,
				tbyte, mbyte, cfg);
		end else begin
			d = data_space(idx, (idx <= BLK2_END) ? BLK2_START : BLK3_START,
				FIXED_BYTE_C, FIXED_BYTE_D, cfg);
		end
		return d;
	endfunction

endpackage

[sv/ac_ir_frame_pulse_encoder_top.sv]
// IR remote frame encoder: command build on load, envelope sequencing on tick.
// Depends on acirfpe_pkg.
//
//  channel   | dir | handshake                 | contents
//  s_axis    | in  | tvalid/tready             | tuser: action; tdata: temp, fan, mode
//  m_axis    | out | tvalid/tready             | tdata: level, busy, accepted; tlast: end
//  apb       | in  | psel/penable/pwrite/pready| 7 config registers at 4*i
//
// Each word passes from the input register through the frame logic into the result
// register. One word per cycle sustained while the output is not stalled; the frame
// state loop (counter, pair index) closes through the frame state registers.
// Reset clears the frame state and restores register defaults.
// A stalled output holds its word; the input register then holds one more word
// and drops s_axis_tready until the result register drains.
module ac_ir_frame_pulse_encoder_top
	import acirfpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [5:0] target_temp, [7:6] fan_speed, [10:8] op_mode
	input  logic        s_axis_tuser,   // [0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [0] ir_level, [1] busy_res, [2] load_accepted
	output logic        m_axis_tlast,   // frame_end
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Input stage
	logic        valid_s1;
	logic        action_s1;
	logic [5:0]  temp_s1;
	logic [1:0]  fan_s1;
	logic [2:0]  mode_s1;

	// Result register
	logic        out_valid_q;
	logic        level_q, busy_q, fend_q, acc_q;

	// Frame state
	cfg_t        cfg_q;
	logic [2:0]  prev_mode_q;
	logic [5:0]  prev_temp_q;
	cmd_byte_t   temp_byte_q, mode_byte_q;
	pair_t       pair_q;
	logic        in_space_q;
	dur_t        ticks_q;
	logic        sending_q;

	logic        advance;
	logic        cfg_wr;
	reg_idx_t    reg_idx;

	// Next-state and result
	logic [2:0]  mode_c;
	cmd_byte_t   mcode_c;
	pair_t       pair_inc;
	logic [2:0]  prev_mode_d;
	logic [5:0]  prev_temp_d;
	cmd_byte_t   temp_byte_d, mode_byte_d;
	pair_t       pair_d;
	logic        in_space_d;
	dur_t        ticks_d;
	logic        sending_d;
	logic        level_d, busy_d, fend_d, acc_d;

	// Handshake
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, acc_q, busy_q, level_q};
	assign m_axis_tlast  = fend_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1 <= s_axis_tuser;
			temp_s1   <= s_axis_tdata[5:0];
			fan_s1    <= s_axis_tdata[7:6];
			mode_s1   <= s_axis_tdata[10:8];
		end
	end

	// Config port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LEAD:  cfg_q.lead      <= pwdata[DURATION_BITS-1:0];
				REG_MARK:  cfg_q.mark      <= pwdata[DURATION_BITS-1:0];
				REG_ONE:   cfg_q.one_sp    <= pwdata[DURATION_BITS-1:0];
				REG_ZERO:  cfg_q.zero_sp   <= pwdata[DURATION_BITS-1:0];
				REG_GAP:   cfg_q.gap       <= pwdata[DURATION_BITS-1:0];
				REG_TRAIL: cfg_q.trail     <= pwdata[DURATION_BITS-1:0];
				REG_OFFS:  cfg_q.temp_bias <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LEAD:  prdata = 32'(cfg_q.lead);
			REG_MARK:  prdata = 32'(cfg_q.mark);
			REG_ONE:   prdata = 32'(cfg_q.one_sp);
			REG_ZERO:  prdata = 32'(cfg_q.zero_sp);
			REG_GAP:   prdata = 32'(cfg_q.gap);
			REG_TRAIL: prdata = 32'(cfg_q.trail);
			REG_OFFS:  prdata = 32'(cfg_q.temp_bias);
			default:   prdata = '0;
		endcase
	end

	// Command build and frame sequencing for the word in the input stage
	assign mode_c   = (mode_s1 > MODE_AUTO) ? MODE_AUTO : mode_s1;
	assign mcode_c  = mode_code(mode_c) |
		(((mode_c == prev_mode_q) && (temp_s1 != prev_temp_q)) ? SAME_MODE_FLAG : 8'h00);
	assign pair_inc = pair_q + 8'd1;

	always_comb begin
		prev_mode_d = prev_mode_q;
		prev_temp_d = prev_temp_q;
		temp_byte_d = temp_byte_q;
		mode_byte_d = mode_byte_q;
		pair_d      = pair_q;
		in_space_d  = in_space_q;
		ticks_d     = ticks_q;
		sending_d   = sending_q;
		level_d     = 1'b0;
		busy_d      = 1'b0;
		fend_d      = 1'b0;
		acc_d       = 1'b0;
		if (action_s1 == ACT_LOAD) begin
			busy_d = 1'b1;
			if (!sending_q) begin
				temp_byte_d = {2'b00, temp_s1} - {2'b00, cfg_q.temp_bias} + fan_code(fan_s1);
				mode_byte_d = mcode_c;
				prev_mode_d = mode_c;
				prev_temp_d = temp_s1;
				pair_d      = '0;
				in_space_d  = 1'b0;
				ticks_d     = dur_or_one(cfg_q.lead);
				sending_d   = 1'b1;
				acc_d       = 1'b1;
			end
		end else if (sending_q) begin
			busy_d  = 1'b1;
			level_d = !in_space_q;
			if (ticks_q <= dur_t'(1)) begin
				if (!in_space_q) begin
					in_space_d = 1'b1;
					ticks_d    = half_duration(pair_q, 1'b1, cfg_q, temp_byte_q, mode_byte_q);
				end else if (pair_q >= LAST_PAIR) begin
					fend_d     = 1'b1;
					sending_d  = 1'b0;
					in_space_d = 1'b0;
					ticks_d    = '0;
					pair_d     = '0;
				end else begin
					pair_d     = pair_inc;
					in_space_d = 1'b0;
					ticks_d    = half_duration(pair_inc, 1'b0, cfg_q, temp_byte_q, mode_byte_q);
				end
			end else begin
				ticks_d = ticks_q - dur_t'(1);
			end
		end
	end

	// Frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mode_q <= MODE_OFF;
			prev_temp_q <= '0;
			temp_byte_q <= '0;
			mode_byte_q <= '0;
			pair_q      <= '0;
			in_space_q  <= 1'b0;
			ticks_q     <= '0;
			sending_q   <= 1'b0;
		end else if (advance) begin
			prev_mode_q <= prev_mode_d;
			prev_temp_q <= prev_temp_d;
			temp_byte_q <= temp_byte_d;
			mode_byte_q <= mode_byte_d;
			pair_q      <= pair_d;
			in_space_q  <= in_space_d;
			ticks_q     <= ticks_d;
			sending_q   <= sending_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			level_q <= level_d;
			busy_q  <= busy_d;
			fend_q  <= fend_d;
			acc_q   <= acc_d;
		end
	end

endmodule

[sv/acirfpe_checker.sv]
// Port-level checks for the IR frame encoder, bound to the top level.
// Depends on ac_ir_frame_pulse_encoder_top_macros.svh.
`include "ac_ir_frame_pulse_encoder_top_macros.svh"

module acirfpe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	// A stalled output word holds
	`ACIR_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")

	// A mark is only sent during a frame
	`ACIR_ASSERT_IMP(a_mark_busy, clk, arst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1], "mark level while not busy")

	// Frame end comes on a space tick of a busy frame, never with a load
	`ACIR_ASSERT_IMP(a_end_space, clk, arst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[1] && !m_axis_tdata[0] && !m_axis_tdata[2], "frame end on bad word")

	// An accepted load word starts a frame and shows space level
	`ACIR_ASSERT_IMP(a_load_word, clk, arst_n, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[1] && !m_axis_tdata[0] && !m_axis_tlast, "accepted load word malformed")

endmodule

bind ac_ir_frame_pulse_encoder_top acirfpe_checker u_acirfpe_checker (.*);
